// ===== hw/rtl/ntc_pkg.sv =====
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned CODE_W     = 12;
  localparam int unsigned MV_W       = 12;
  localparam int unsigned MV_MULT    = 825;
  localparam int unsigned MV_SHIFT   = 10;
  localparam int unsigned MV_PROD_W  = CODE_W + MV_SHIFT;
  localparam int unsigned TABLE_CAP  = 32;
  localparam int unsigned IDX_W      = $clog2(TABLE_CAP);
  localparam int unsigned REM_W      = 16;
  localparam int unsigned DEN_W      = 12;
  localparam int unsigned QUO_W      = 7;
  localparam int unsigned STEP_SCALE = 100;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned STAT_W     = 2;
  localparam int          TEMP_BASE  = -400;

  localparam logic signed [TEMP_W-1:0] COLD_TEMP = 16'sh8001;
  localparam logic signed [TEMP_W-1:0] HOT_TEMP  = 16'sh7FFF;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_COLD = 2'd1,
    STATUS_HOT  = 2'd2
  } ntc_status_e;

  typedef struct packed {
    ntc_status_e      status;
    logic [IDX_W-1:0] idx;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } ntc_div_t;

  // divider voltage in mV, one point every 10 C from -40 C
  function automatic logic [MV_W-1:0] volt_mv(input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      5'd0:    v = 12'd2863;
      5'd1:    v = 12'd2559;
      5'd2:    v = 12'd2160;
      5'd3:    v = 12'd1715;
      5'd4:    v = 12'd1287;
      5'd5:    v = 12'd926;
      5'd6:    v = 12'd649;
      5'd7:    v = 12'd450;
      5'd8:    v = 12'd311;
      5'd9:    v = 12'd218;
      5'd10:   v = 12'd153;
      5'd11:   v = 12'd109;
      5'd12:   v = 12'd79;
      5'd13:   v = 12'd58;
      5'd14:   v = 12'd43;
      5'd15:   v = 12'd32;
      5'd16:   v = 12'd25;
      5'd17:   v = 12'd19;
      5'd18:   v = 12'd15;
      5'd19:   v = 12'd12;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ntc_front.sv =====
`timescale 1ns / 1ps

module ntc_front #(
  parameter int unsigned TABLE_POINTS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ntc_pkg::CODE_W-1:0]       in_code_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ntc_pkg::ntc_div_t                out_data_o
);

  localparam int unsigned IDX_W = ntc_pkg::IDX_W;
  localparam int unsigned MV_W  = ntc_pkg::MV_W;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [ntc_pkg::MV_PROD_W-1:0] prod;
  logic [MV_W-1:0]               mv_q;

  logic [IDX_W-1:0]      sel;
  ntc_pkg::ntc_status_e  status_d;
  ntc_pkg::ntc_status_e  status_q;
  logic [IDX_W-1:0]      idx_q;
  logic [MV_W-1:0]       hi_q, lo_q, mv2_q;

  ntc_pkg::ntc_div_t     data_d, data_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: code to mV
  assign prod = ntc_pkg::MV_PROD_W'(in_code_i) * ntc_pkg::MV_PROD_W'(ntc_pkg::MV_MULT);

  // stage 2: bracket search, first point below mV
  always_comb begin
    sel = IDX_W'(TABLE_POINTS - 1);
    for (int j = int'(TABLE_POINTS) - 2; j >= 1; j--) begin
      if (ntc_pkg::volt_mv(IDX_W'(j)) < mv_q) sel = IDX_W'(j);
    end
    if (mv_q >= ntc_pkg::volt_mv('0)) begin
      status_d = ntc_pkg::STATUS_COLD;
    end else if (mv_q <= ntc_pkg::volt_mv(IDX_W'(TABLE_POINTS - 1))) begin
      status_d = ntc_pkg::STATUS_HOT;
    end else begin
      status_d = ntc_pkg::STATUS_OK;
    end
  end

  // stage 3: numerator and denominator
  always_comb begin
    data_d.status = status_q;
    data_d.idx    = idx_q;
    data_d.rem    = ntc_pkg::REM_W'((hi_q - mv2_q) * ntc_pkg::STEP_SCALE);
    data_d.den    = ntc_pkg::DEN_W'(hi_q - lo_q);
    data_d.quo    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) mv_q <= prod[ntc_pkg::MV_PROD_W-1 -: MV_W];
    if (rdy2 && v1_q) begin
      status_q <= status_d;
      idx_q    <= sel - IDX_W'(1);
      hi_q     <= ntc_pkg::volt_mv(sel - IDX_W'(1));
      lo_q     <= ntc_pkg::volt_mv(sel);
      mv2_q    <= mv_q;
    end
    if (rdy3 && v2_q) data_q <= data_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/ntc_div_step.sv =====
`timescale 1ns / 1ps

module ntc_div_step #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ntc_pkg::ntc_div_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ntc_pkg::ntc_div_t out_data_o
);

  localparam int unsigned CMP_W = ntc_pkg::DEN_W + ntc_pkg::QUO_W;

  logic              valid_q;
  logic [CMP_W-1:0]  den_sh;
  logic [CMP_W-1:0]  rem_ext;
  ntc_pkg::ntc_div_t data_d, data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // one restoring quotient bit
  always_comb begin
    den_sh  = CMP_W'(in_data_i.den) << SHIFT;
    rem_ext = CMP_W'(in_data_i.rem);
    data_d  = in_data_i;
    if (rem_ext >= den_sh) begin
      data_d.rem        = ntc_pkg::REM_W'(rem_ext - den_sh);
      data_d.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/ntc_adc_to_celsius_interp.sv =====
`timescale 1ns / 1ps

// Converts a 12-bit thermistor ADC code to temperature in tenths of a degree C by
// linear interpolation over a descending 10-degree voltage table (-40 C to 150 C).
// One code is accepted every cycle unless the output stalls. From input transfer to
// result, one stage scales the code to mV, one searches the table, one forms the
// interpolation numerator, seven stages of a restoring divider yield one quotient
// bit each, and one output register follows. Readings above the table come out as
// -32767 with tuser cold, below it as 32767 with tuser hot. TABLE_POINTS (2 to 32)
// sets how many table points are used; points past the twentieth read as 0 mV.

module ntc_adc_to_celsius_interp #(
  parameter int unsigned TABLE_POINTS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] adc_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] temperature_tenths
  output logic [1:0]  m_axis_tuser   // [1:0] range_status
);

  localparam int unsigned QUO_W  = ntc_pkg::QUO_W;
  localparam int unsigned TEMP_W = ntc_pkg::TEMP_W;

  logic              div_valid [QUO_W+1];
  logic              div_ready [QUO_W+1];
  ntc_pkg::ntc_div_t div_data  [QUO_W+1];

  logic                     out_valid_q;
  logic                     last_ready;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  ntc_pkg::ntc_status_e     status_q;

  ntc_front #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_code_i   (s_axis_tdata[ntc_pkg::CODE_W-1:0]),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_data[0])
  );

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    ntc_div_step #(
      .SHIFT (QUO_W - 1 - s)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[s]),
      .in_ready_o  (div_ready[s]),
      .in_data_i   (div_data[s]),
      .out_valid_o (div_valid[s+1]),
      .out_ready_i (div_ready[s+1]),
      .out_data_o  (div_data[s+1])
    );
  end

  assign last_ready        = !out_valid_q || m_axis_tready;
  assign div_ready[QUO_W]  = last_ready;

  always_comb begin
    unique case (div_data[QUO_W].status)
      ntc_pkg::STATUS_COLD: temp_d = ntc_pkg::COLD_TEMP;
      ntc_pkg::STATUS_HOT:  temp_d = ntc_pkg::HOT_TEMP;
      default: begin
        temp_d = TEMP_W'(ntc_pkg::TEMP_BASE)
               + TEMP_W'(div_data[QUO_W].idx * ntc_pkg::STEP_SCALE)
               + TEMP_W'(div_data[QUO_W].quo);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_ready) begin
      out_valid_q <= div_valid[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_ready && div_valid[QUO_W]) begin
      temp_q   <= temp_d;
      status_q <= div_data[QUO_W].status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = temp_q;
  assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
  a_empty_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[QUO_W] && div_data[QUO_W].status == ntc_pkg::STATUS_OK)
      |-> (div_data[QUO_W].rem < ntc_pkg::REM_W'(div_data[QUO_W].den)))
    else $error("divider remainder not below divisor");

  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[QUO_W] && div_data[QUO_W].status == ntc_pkg::STATUS_OK)
      |-> (div_data[QUO_W].quo < ntc_pkg::QUO_W'(ntc_pkg::STEP_SCALE)))
    else $error("interpolation step out of range");

  a_temp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ntc_pkg::STATUS_OK)
      |-> ($signed(m_axis_tdata) >= -16'sd400 && $signed(m_axis_tdata) <= 16'sd2699))
    else $error("in-range temperature outside table span");

  a_cold_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ntc_pkg::STATUS_COLD)
      |-> (m_axis_tdata == ntc_pkg::COLD_TEMP))
    else $error("cold status with wrong code");
`endif

endmodule
